/* rtl/ssvp_pkg.sv */
// shared constants and types of the sliced sample voice player
package ssvp_pkg;

  localparam int VOICES_DEF       = 8;
  // sample depth must be a power of two: sample addresses wrap by masking
  localparam int SAMPLE_DEPTH_DEF = 65536;
  localparam int MAX_SLICES_DEF   = 256;

  localparam logic [6:0] ROOT_NOTE = 7'd36;

  localparam int GAIN_W   = 7;
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 17;
  localparam int START_W  = 16;
  localparam int SLICE_W  = 8;
  localparam int MIX_W    = 26;
  localparam int NSL_W    = 9;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_SAMPLE = 3'd1;
  localparam logic [2:0] MODE_SLICE  = 3'd2;
  localparam logic [2:0] MODE_ORDER  = 3'd3;
  localparam logic [2:0] MODE_NOTE   = 3'd4;

  // register select is paddr bit 2
  localparam logic REG_NUM_SLICES = 1'b0;
  localparam logic REG_MONO       = 1'b1;

  // one mixer beat: sample word arrives from memory this cycle
  typedef struct packed {
    logic              valid;
    logic [GAIN_W-1:0] gain;
  } mix_ctl_t;

endpackage

/* rtl/ssvp_sample_mem.sv */
// stereo sample memory, one write port and one registered read port
module ssvp_sample_mem #(
  parameter int SAMPLE_DEPTH = ssvp_pkg::SAMPLE_DEPTH_DEF,
  parameter int AW           = $clog2(SAMPLE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [SAMPLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ssvp_tables.sv */
// slice table (start and length) and order table memories
module ssvp_tables #(
  parameter int MAX_SLICES = ssvp_pkg::MAX_SLICES_DEF,
  parameter int SW         = $clog2(MAX_SLICES)
) (
  input  logic                        clk,
  input  logic                        slice_we,
  input  logic [SW-1:0]               slice_waddr,
  input  logic [ssvp_pkg::START_W-1:0] slice_wstart,
  input  logic [ssvp_pkg::POS_W-1:0]  slice_wlen,
  input  logic [SW-1:0]               slice_raddr,
  output logic [ssvp_pkg::START_W-1:0] slice_rstart,
  output logic [ssvp_pkg::POS_W-1:0]  slice_rlen,
  input  logic                        order_we,
  input  logic [SW-1:0]               order_waddr,
  input  logic [ssvp_pkg::SLICE_W-1:0] order_wdata,
  input  logic [SW-1:0]               order_raddr,
  output logic [ssvp_pkg::SLICE_W-1:0] order_rdata
);

  localparam int SLW = ssvp_pkg::START_W + ssvp_pkg::POS_W;

  logic [SLW-1:0]               slice_mem [MAX_SLICES];
  logic [ssvp_pkg::SLICE_W-1:0] order_mem [MAX_SLICES];
  logic [SLW-1:0]               slice_q;

  always_ff @(posedge clk) begin
    if (slice_we) begin
      slice_mem[slice_waddr] <= {slice_wstart, slice_wlen};
    end
    slice_q <= slice_mem[slice_raddr];
  end

  always_ff @(posedge clk) begin
    if (order_we) begin
      order_mem[order_waddr] <= order_wdata;
    end
    order_rdata <= order_mem[order_raddr];
  end

  assign slice_rstart = slice_q[SLW-1:ssvp_pkg::POS_W];
  assign slice_rlen   = slice_q[ssvp_pkg::POS_W-1:0];

endmodule

/* rtl/ssvp_mixer.sv */
// gain multiply and stereo accumulate, two stages
module ssvp_mixer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  ssvp_pkg::mix_ctl_t       ctl,
  input  logic [31:0]              word,
  input  logic                     mono,
  output logic                     busy,
  output logic [ssvp_pkg::MIX_W-1:0] acc_l,
  output logic [ssvp_pkg::MIX_W-1:0] acc_r
);

  localparam int PW = ssvp_pkg::GAIN_W + 1 + ssvp_pkg::SAMPLE_W;

  logic signed [ssvp_pkg::SAMPLE_W-1:0] left, right;
  logic signed [ssvp_pkg::GAIN_W:0]     gain_s;
  logic signed [PW-1:0]                 prod_l_r, prod_r_r;
  logic                                 pv_r;
  logic [ssvp_pkg::MIX_W-1:0]           acc_l_r, acc_r_r;

  assign left   = word[ssvp_pkg::SAMPLE_W-1:0];
  assign right  = mono ? word[ssvp_pkg::SAMPLE_W-1:0] : word[31:ssvp_pkg::SAMPLE_W];
  assign gain_s = {1'b0, ctl.gain};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.valid;
    end
    prod_l_r <= PW'(gain_s * left);
    prod_r_r <= PW'(gain_s * right);
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (pv_r) begin
      // sums wrap within the mix width
      acc_l_r <= acc_l_r + ssvp_pkg::MIX_W'(prod_l_r);
      acc_r_r <= acc_r_r + ssvp_pkg::MIX_W'(prod_r_r);
    end
  end

  assign busy  = pv_r;
  assign acc_l = acc_l_r;
  assign acc_r = acc_r_r;

endmodule

/* rtl/sliced_sample_voice_player.sv */
// top level: item sequencer, voice state, config port and result register
//
// channel | dir | handshake             | payload
// in_     | in  | in_valid / in_ready   | mode, sample, slice, order, note fields
// out_    | out | out_valid / out_ready | mix_left/right, flags, voice_used
// cfg_    | in  | apb psel/penable      | num_slices (0x0), source_is_mono (0x4)
//
// writes and notes failing the index check go straight to the done state, other notes
// pass through the note state first; a tick streams one voice per cycle through slice
// table read, sample memory read, multiply and accumulate. one item is worked on at a
// time; a new beat is taken while the previous result waits in the output register.
// rst_n is synchronous and clears voices, state and config; memories keep contents.
module sliced_sample_voice_player #(
  parameter int VOICES       = ssvp_pkg::VOICES_DEF,
  parameter int SAMPLE_DEPTH = ssvp_pkg::SAMPLE_DEPTH_DEF,
  parameter int MAX_SLICES   = ssvp_pkg::MAX_SLICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_sample_address,
  input  logic signed [15:0] in_sample_left,
  input  logic signed [15:0] in_sample_right,
  input  logic [7:0]  in_slice_number,
  input  logic [15:0] in_slice_start,
  input  logic [16:0] in_slice_length,
  input  logic [7:0]  in_order_position,
  input  logic [7:0]  in_order_target,
  input  logic [6:0]  in_note,
  input  logic [6:0]  in_velocity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [25:0] out_mix_left,
  output logic signed [25:0] out_mix_right,
  output logic        out_frame_valid,
  output logic        out_note_accepted,
  output logic [2:0]  out_voice_used,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW  = $clog2(SAMPLE_DEPTH);
  localparam int SW  = $clog2(MAX_SLICES);
  localparam int NW  = $clog2(MAX_SLICES + 1);
  localparam int CW  = $clog2(VOICES + 1);
  localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int MW  = ssvp_pkg::MIX_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_NOTE = 4'b0010,
    ST_TICK = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [ssvp_pkg::NSL_W-1:0] num_slices_r;
  logic                       mono_r;
  logic [NW-1:0]              n_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_slices_r <= '0;
      mono_r       <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == ssvp_pkg::REG_NUM_SLICES) begin
        num_slices_r <= cfg_pwdata[ssvp_pkg::NSL_W-1:0];
      end else begin
        mono_r <= cfg_pwdata[0];
      end
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == ssvp_pkg::REG_MONO) ? {31'd0, mono_r}
                                                           : 32'(num_slices_r);
  assign n_cnt = (32'(num_slices_r) > MAX_SLICES) ? NW'(MAX_SLICES) : NW'(num_slices_r);

  // voice state
  logic                         active_r [VOICES];
  logic [ssvp_pkg::SLICE_W-1:0] vslice_r [VOICES];
  logic [ssvp_pkg::POS_W-1:0]   vpos_r   [VOICES];
  logic [ssvp_pkg::GAIN_W-1:0]  vgain_r  [VOICES];

  // item latch
  logic [6:0] vel_r;

  // result waiting to be posted
  logic [MW-1:0] res_l_r, res_r_r;
  logic          res_frame_r, res_acc_r;
  logic [2:0]    res_voice_r;

  // tick pipeline
  logic [CW-1:0]  iss_r;
  logic           s1_v_r, s2_v_r;
  logic [VIW-1:0] s1_voice_r;
  logic [ssvp_pkg::GAIN_W-1:0] s2_gain_r;

  logic in_fire;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // note checks on the incoming beat
  logic [6:0] logical;
  logic       note_ok;
  assign logical = in_note - ssvp_pkg::ROOT_NOTE;
  assign note_ok = (in_velocity != 7'd0) && (in_note >= ssvp_pkg::ROOT_NOTE)
                   && (32'(logical) < 32'(n_cnt));

  // memories
  logic          smem_we;
  logic [AW-1:0] smem_raddr;
  logic [31:0]   smem_q;
  logic [SW-1:0] slice_raddr;
  logic [ssvp_pkg::START_W-1:0] slice_start_q;
  logic [ssvp_pkg::POS_W-1:0]   slice_len_q;
  logic [ssvp_pkg::SLICE_W-1:0] order_q;

  assign smem_we = in_fire && (in_mode == ssvp_pkg::MODE_SAMPLE);

  ssvp_sample_mem #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .AW(AW)) u_smem (
    .clk   (clk),
    .we    (smem_we),
    .waddr (AW'(in_sample_address)),
    .wdata ({in_sample_right, in_sample_left}),
    .raddr (smem_raddr),
    .rdata (smem_q)
  );

  ssvp_tables #(.MAX_SLICES(MAX_SLICES), .SW(SW)) u_tables (
    .clk          (clk),
    .slice_we     (in_fire && (in_mode == ssvp_pkg::MODE_SLICE)
                   && (32'(in_slice_number) < MAX_SLICES)),
    .slice_waddr  (SW'(in_slice_number)),
    .slice_wstart (in_slice_start),
    .slice_wlen   (in_slice_length),
    .slice_raddr  (slice_raddr),
    .slice_rstart (slice_start_q),
    .slice_rlen   (slice_len_q),
    .order_we     (in_fire && (in_mode == ssvp_pkg::MODE_ORDER)
                   && (32'(in_order_position) < MAX_SLICES)),
    .order_waddr  (SW'(in_order_position)),
    .order_wdata  (in_order_target),
    .order_raddr  (SW'(logical)),
    .order_rdata  (order_q)
  );

  // stage 0: slice lookup for the voice being issued
  logic [VIW-1:0] iss_idx;
  logic           iss_more;
  assign iss_idx     = iss_r[VIW-1:0];
  assign iss_more    = (32'(iss_r) < VOICES);
  assign slice_raddr = SW'(vslice_r[iss_idx]);

  // stage 1: retire check and sample address
  logic           s1_live;
  logic [17:0]    addr_sum;
  assign s1_live    = s1_v_r && (vpos_r[s1_voice_r] < slice_len_q);
  assign addr_sum   = 18'(slice_start_q) + 18'(vpos_r[s1_voice_r]);
  assign smem_raddr = AW'(addr_sum);

  // mixer
  ssvp_pkg::mix_ctl_t mix_ctl;
  logic               mix_busy, mix_clear;
  logic [MW-1:0]      acc_l, acc_r;
  assign mix_ctl.valid = s2_v_r;
  assign mix_ctl.gain  = s2_gain_r;
  assign mix_clear     = in_fire;

  ssvp_mixer u_mixer (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (mix_clear),
    .ctl   (mix_ctl),
    .word  (smem_q),
    .mono  (mono_r),
    .busy  (mix_busy),
    .acc_l (acc_l),
    .acc_r (acc_r)
  );

  // lowest free voice, voice 0 when all busy
  logic [VIW-1:0] pick;
  logic           found;
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int v = 0; v < VOICES; v++) begin
      if (!found && !active_r[v]) begin
        pick  = VIW'(v);
        found = 1'b1;
      end
    end
  end

  logic phys_ok, tick_end, out_free;
  assign phys_ok  = (32'(order_q) < 32'(n_cnt));
  assign tick_end = !iss_more && !s1_v_r && !s2_v_r && !mix_busy;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_mode == ssvp_pkg::MODE_TICK) begin
            state_nxt = ST_TICK;
          end else if (in_mode == ssvp_pkg::MODE_NOTE && note_ok) begin
            state_nxt = ST_NOTE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_NOTE: state_nxt = ST_DONE;
      ST_TICK: if (tick_end) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iss_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        active_r[v] <= 1'b0;
        vslice_r[v] <= '0;
        vpos_r[v]   <= '0;
        vgain_r[v]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // stale slices are skipped entirely
      s1_v_r  <= (state_r == ST_TICK) && iss_more && active_r[iss_idx]
                 && (32'(vslice_r[iss_idx]) < 32'(n_cnt));
      s2_v_r  <= (state_r == ST_TICK) && s1_live;
      if (in_fire) begin
        iss_r <= '0;
      end
      if (state_r == ST_TICK) begin
        if (iss_more) begin
          s1_voice_r <= iss_idx;
          iss_r      <= iss_r + CW'(1);
        end
        if (s1_v_r) begin
          if (s1_live) begin
            vpos_r[s1_voice_r] <= vpos_r[s1_voice_r] + ssvp_pkg::POS_W'(1);
            s2_gain_r <= vgain_r[s1_voice_r];
          end else begin
            active_r[s1_voice_r] <= 1'b0;
          end
        end
      end
      if (state_r == ST_NOTE && phys_ok) begin
        active_r[pick] <= 1'b1;
        vslice_r[pick] <= order_q;
        vpos_r[pick]   <= '0;
        vgain_r[pick]  <= vel_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      vel_r       <= in_velocity;
      res_l_r     <= '0;
      res_r_r     <= '0;
      res_frame_r <= (in_mode == ssvp_pkg::MODE_TICK);
      res_acc_r   <= 1'b0;
      res_voice_r <= '0;
    end
    if (state_r == ST_NOTE && phys_ok) begin
      res_acc_r   <= 1'b1;
      res_voice_r <= 3'(pick);
    end
    if (state_r == ST_TICK && tick_end) begin
      res_l_r <= acc_l;
      res_r_r <= acc_r;
    end
  end

  // output register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_mix_left      <= res_l_r;
      out_mix_right     <= res_r_r;
      out_frame_valid   <= res_frame_r;
      out_note_accepted <= res_acc_r;
      out_voice_used    <= res_voice_r;
    end
  end

  assign out_valid = out_valid_r;

  // assertions
  a_pipe_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r || s2_v_r) |-> state_r == ST_TICK)
    else $error("tick pipeline active outside tick");

  a_frame_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_valid |-> !out_note_accepted)
    else $error("frame result flags a note");

  a_nonframe_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_valid |-> out_mix_left == 0 && out_mix_right == 0)
    else $error("nonzero mix on a non-tick result");

  a_note_voice: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NOTE && phys_ok |=> active_r[$past(pick)])
    else $error("accepted note left its voice inactive");

endmodule
